// ----- hdl/lru_key_value_cache_defines.svh -----
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Check a property outside reset.
`define LKV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property at every edge, reset included.
`define LKV_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- hdl/lkv_pkg.sv -----
package lkv_pkg;

  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int OccW = 5;
  localparam int CapW = 5;

  localparam logic [CapW-1:0] CapReset  = 5'd16;
  localparam logic [ValW-1:0] MissValue = '1;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_SET = 1'b1
  } action_e;

  typedef struct packed {
    action_e         action;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] read_value;
    logic [OccW-1:0] occupancy;
  } res_t;

endpackage

// ----- hdl/lru_key_value_cache.sv -----
// Fully associative key/value cache with least-recently-used replacement,
// DEPTH entries held in flip-flops. An item is a get (tuser = 0) or a set
// (tuser = 1) of a 32-bit key; every item yields one result giving hit, the
// read value (stored value on a get hit, all ones on a get miss, zero on a
// set) and the occupancy after the item. Items are taken at one per cycle
// while the output is not held: an accepted item sits in an input register,
// all keys are compared and all recency ranks updated as it advances, and
// the result is captured in the output register. The output register and
// the input register keep full rate while the output is ready. capacity
// (1..16, zero reads as 1, values above DEPTH as DEPTH) may be written only
// while the block is idle; lowering it below the occupancy never drops entries.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,      // capacity
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [63:0]     s_axis_tdata_i,   // key [31:0], value [63:32]
  input  logic [0:0]      s_axis_tuser_i,   // action
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [39:0]     m_axis_tdata_o,   // read_value [31:0], occupancy [36:32], zeros
  output logic [0:0]      m_axis_tuser_o    // hit
);

  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CapW-1:0] cap_q;

  logic            s_valid_q;
  req_t            s_req_q;
  logic            o_valid_q;
  res_t            o_res_q;
  logic            advance;

  logic [KeyW-1:0] key_q   [DEPTH];
  logic [ValW-1:0] value_q [DEPTH];
  logic [RW-1:0]   rank_q  [DEPTH];
  logic [RW-1:0]   rank_d  [DEPTH];
  logic [DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]   count_q, count_d;

  logic [DEPTH-1:0] match_vec, victim_vec, valid_ev, slot_vec;
  logic            hit;
  logic [RW-1:0]   found_rank;
  logic [ValW-1:0] found_val;
  logic [CW-1:0]   eff_cap;
  logic            is_set, miss_set, evict, insert;
  res_t            res_d;

  // Handshake
  assign advance         = s_valid_q && (!o_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s_valid_q || advance;
  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {3'b000, o_res_q.occupancy, o_res_q.read_value};
  assign m_axis_tuser_o  = o_res_q.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s_req_q.action <= action_e'(s_axis_tuser_i[0]);
      s_req_q.key    <= s_axis_tdata_i[31:0];
      s_req_q.value  <= s_axis_tdata_i[63:32];
    end
    if (advance) begin
      o_res_q <= res_d;
    end
  end

  // Lookup and replacement choice
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_q);
    end

    found_rank = '0;
    found_val  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i]  = valid_q[i] && (key_q[i] == s_req_q.key);
      // ranks of valid entries form 0..count-1, so the oldest has count-1
      victim_vec[i] = valid_q[i] && (CW'(rank_q[i]) == count_q - CW'(1));
      if (match_vec[i]) begin
        found_rank = found_rank | rank_q[i];
        found_val  = found_val | value_q[i];
      end
    end
    hit = |match_vec;

    is_set   = (s_req_q.action == ACT_SET);
    miss_set = is_set && !hit;
    evict    = miss_set && (count_q >= eff_cap) && (count_q != '0);
    valid_ev = evict ? (valid_q & ~victim_vec) : valid_q;
    // lowest free entry
    slot_vec = ~valid_ev & (valid_ev + DEPTH'(1));
    insert   = miss_set && (|slot_vec);

    count_d = count_q - CW'(evict) + CW'(insert);
    valid_d = insert ? (valid_ev | slot_vec) : valid_ev;

    for (int i = 0; i < DEPTH; i++) begin
      rank_d[i] = rank_q[i];
      if (hit) begin
        if (match_vec[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && rank_q[i] < found_rank) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end
      end else if (insert) begin
        if (slot_vec[i] || (evict && victim_vec[i])) begin
          rank_d[i] = '0;
        end else if (valid_ev[i]) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end
      end
    end

    res_d.hit        = hit;
    res_d.occupancy  = OccW'(count_d);
    if (is_set) begin
      res_d.read_value = '0;
    end else if (hit) begin
      res_d.read_value = found_val;
    end else begin
      res_d.read_value = MissValue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (advance) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (advance && insert && slot_vec[i]) begin
        key_q[i]   <= s_req_q.key;
        value_q[i] <= s_req_q.value;
      end else if (advance && is_set && match_vec[i]) begin
        value_q[i] <= s_req_q.value;
      end
    end
  end

  `LKV_ASSERT(a_count_matches_valid, clk_i, rst_ni, $countones(valid_q) == int'(count_q))
  `LKV_ASSERT(a_key_unique, clk_i, rst_ni, s_valid_q |-> $onehot0(match_vec))
  `LKV_ASSERT(a_one_victim, clk_i, rst_ni, (s_valid_q && evict) |-> $onehot(victim_vec))
  `LKV_ASSERT(a_result_follows, clk_i, rst_ni, advance |=> o_valid_q)
  `LKV_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!o_valid_q && count_q == '0))

endmodule

// ----- tb/sv/lru_key_value_cache_tb.sv -----
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int Depth       = 16;
  localparam int DrainCycles = 6;
  localparam int PhaseItems  = 136;
  localparam int NumPhases   = 11;
  localparam int MaxPrinted  = 40;

  // Occupancy never shrinks, so capacities mostly climb across phases.
  localparam logic [CapW-1:0] PhaseCaps [NumPhases] =
    '{5'd1, 5'd0, 5'd4, 5'd2, 5'd7, 5'd9, 5'd13, 5'd16, 5'd31, 5'd17, 5'd3};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;
  logic            s_valid = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic            m_ready = 1'b0;
  logic [39:0]     m_axis_tdata_o;
  logic [0:0]      m_axis_tuser_o;
  req_t            cur_req = '0;

  // Predictor state
  logic [KeyW-1:0] line_key [Depth];
  logic [ValW-1:0] line_val [Depth];
  bit              line_valid [Depth];
  int unsigned     line_rank [Depth];
  int unsigned     line_count;
  logic [CapW-1:0] cap_setting = CapReset;

  req_t queued_requests [$];
  res_t predicted_responses [$];
  res_t want_res;

  bit calm = 1'b0;
  int outstanding;
  int errors;
  int printed;
  int gets;
  int sets;
  int hits;
  int evictions;
  int checked;
  int cap_writes;

  always #2 clk_i = ~clk_i;

  lru_key_value_cache #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i ({cur_req.value, cur_req.key}),
    .s_axis_tuser_i (cur_req.action),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Move entry idx to the front of the recency order.
  function automatic void promote(input int idx);
    int unsigned r;
    r = line_rank[idx];
    for (int i = 0; i < Depth; i++) begin
      if (line_valid[i] && line_rank[i] < r) begin
        line_rank[i]++;
      end
    end
    line_rank[idx] = 0;
  endfunction

  function automatic res_t cache_access(input req_t rq);
    res_t        res;
    int          found;
    int          victim;
    int          slot;
    int unsigned eff_cap;
    int unsigned best;
    found = -1;
    for (int i = 0; i < Depth; i++) begin
      if (found < 0 && line_valid[i] && line_key[i] == rq.key) begin
        found = i;
      end
    end
    res.hit        = (found >= 0);
    res.read_value = '0;
    if (rq.action == ACT_GET) begin
      if (found >= 0) begin
        promote(found);
        res.read_value = line_val[found];
      end else begin
        res.read_value = MissValue;
      end
    end else if (found >= 0) begin
      line_val[found] = rq.value;
      promote(found);
    end else begin
      eff_cap = (cap_setting == 0) ? 1 : (cap_setting > Depth) ? Depth : cap_setting;
      if (line_count >= eff_cap && line_count > 0) begin
        victim = -1;
        best   = 0;
        for (int i = 0; i < Depth; i++) begin
          if (line_valid[i] && (victim < 0 || line_rank[i] > best)) begin
            victim = i;
            best   = line_rank[i];
          end
        end
        if (victim >= 0) begin
          line_valid[victim] = 1'b0;
          line_rank[victim]  = 0;
          line_count--;
          evictions++;
        end
      end
      slot = -1;
      for (int i = 0; i < Depth; i++) begin
        if (slot < 0 && !line_valid[i]) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < Depth; i++) begin
          if (line_valid[i]) begin
            line_rank[i]++;
          end
        end
        line_valid[slot] = 1'b1;
        line_key[slot]   = rq.key;
        line_val[slot]   = rq.value;
        line_rank[slot]  = 0;
        line_count++;
      end
    end
    res.occupancy = line_count[OccW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (printed < MaxPrinted) begin
      printed++;
      $display("[%0t] mismatch on result %0d: %s", $realtime, checked, what);
    end
  endtask

  task automatic push_item(input action_e act, input logic [KeyW-1:0] k,
                           input logic [ValW-1:0] v);
    req_t rq;
    rq.action = act;
    rq.key    = k;
    rq.value  = v;
    queued_requests.push_back(rq);
    outstanding++;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write capacity only once every item has drained out of the block.
  task automatic set_capacity(input logic [CapW-1:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting = v;
    cap_writes++;
  endtask

  // Item driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        predicted_responses.push_back(cache_access(cur_req));
        if (cur_req.action == ACT_GET) begin
          gets++;
        end else begin
          sets++;
        end
      end
      if (!s_valid || s_axis_tready_o) begin
        if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          cur_req <= queued_requests.pop_front();
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (predicted_responses.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tdata %h",
                                    m_axis_tdata_o));
        end else begin
          want_res = predicted_responses.pop_front();
          if (m_axis_tuser_o[0] !== want_res.hit) begin
            report_mismatch($sformatf("hit %b, expected %b", m_axis_tuser_o[0],
                                      want_res.hit));
          end
          if (m_axis_tdata_o[31:0] !== want_res.read_value) begin
            report_mismatch($sformatf("read_value %h, expected %h",
                                      m_axis_tdata_o[31:0], want_res.read_value));
          end
          if (m_axis_tdata_o[36:32] !== want_res.occupancy) begin
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      m_axis_tdata_o[36:32], want_res.occupancy));
          end
          if (want_res.hit) begin
            hits++;
          end
          checked++;
          outstanding--;
        end
      end
      m_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  initial begin
    #2000000;
    $display("lru_key_value_cache regression: fail");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] key_pool [$];
    logic [KeyW-1:0] k;
    int              pool_size;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of key and value, get miss on empty, set hit update.
    push_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_SET, 32'h8000_0000, 32'h7fff_ffff);
    push_item(ACT_SET, 32'h7fff_ffff, 32'h8000_0000);
    push_item(ACT_SET, 32'h0000_0000, 32'hffff_ffff);
    push_item(ACT_SET, 32'hffff_ffff, 32'h0000_0000);
    push_item(ACT_GET, 32'h8000_0000, 32'hffff_ffff);
    push_item(ACT_GET, 32'hffff_ffff, 32'h1234_5678);
    push_item(ACT_SET, 32'h0000_0000, 32'd1234);
    push_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_GET, 32'h1234_5678, 32'h0000_0000);

    // Capacity below occupancy: each set miss swaps out one entry only.
    set_capacity(5'd2);
    push_item(ACT_SET, 32'h0000_00a5, 32'd7);
    push_item(ACT_GET, 32'h7fff_ffff, 32'd0);
    push_item(ACT_SET, 32'h5a5a_5a5a, 32'd9);
    push_item(ACT_GET, 32'h0000_00a5, 32'd0);

    // Zero capacity acts as one.
    set_capacity(5'd0);
    push_item(ACT_SET, 32'd1, 32'd1);
    push_item(ACT_SET, 32'd2, 32'd2);
    push_item(ACT_GET, 32'd1, 32'd0);

    // Capacity above depth saturates.
    set_capacity(5'd31);
    push_item(ACT_SET, 32'd3, 32'd3);
    push_item(ACT_GET, 32'd2, 32'd0);

    for (int p = 0; p < NumPhases; p++) begin
      set_capacity(PhaseCaps[p]);
      calm = (p == 5);
      key_pool.delete();
      pool_size = $urandom_range(2, 36);
      for (int i = 0; i < pool_size; i++) begin
        case ($urandom_range(7))
          0: key_pool.push_back(32'h8000_0000);
          1: key_pool.push_back(32'h7fff_ffff);
          2: key_pool.push_back(32'hffff_ffff);
          default: key_pool.push_back($urandom);
        endcase
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(99) < 80) begin
          k = key_pool[$urandom_range(pool_size - 1)];
        end else begin
          k = $urandom;
        end
        push_item(action_e'($urandom_range(1)), k, $urandom);
      end
    end

    wait_drained();
    calm = 1'b0;
    $display("covered %0d items: %0d gets, %0d sets, %0d hits, %0d evictions",
             gets + sets, gets, sets, hits, evictions);
    $display("%0d capacity writes, %0d results checked, %0d mismatches",
             cap_writes, checked, errors);
    if (errors == 0) begin
      $display("lru_key_value_cache regression: pass");
    end else begin
      $display("lru_key_value_cache regression: fail");
    end
    $finish;
  end

endmodule
